// File: design/mrf_pkg.sv
`timescale 1ns / 1ps

package mrf_pkg;

	localparam logic [1:0] OP_READ_HOLDING = 2'd0;
	localparam logic [1:0] OP_WRITE_SINGLE = 2'd1;
	localparam logic [1:0] OP_WRITE_MULTI  = 2'd2;
	localparam logic [1:0] OP_VALUE        = 2'd3;

	localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
	localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
	localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [15:0] MAX_MULTI_COUNT = 16'd123;
	localparam int          HDR_BYTES       = 7;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  slave_address;
		logic [15:0] register_address;
		logic [15:0] quantity_or_value;
		logic [15:0] register_value;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
		logic       error;
	} tx_t;

	typedef struct packed {
		logic                      err;
		logic                      crc_init;
		logic                      crc_append;
		logic [2:0]                nbytes;
		logic [HDR_BYTES-1:0][7:0] data;
	} cmd_t;

	function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: design/mrf_front.sv
`timescale 1ns / 1ps

module mrf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  mrf_pkg::req_t req,
	output mrf_pkg::cmd_t cmd
);
	import mrf_pkg::*;

	logic       pending_q;
	logic [6:0] remaining_q;
	logic       bad_count;

	always_comb begin
		bad_count = !(req.quantity_or_value inside {[16'd1:MAX_MULTI_COUNT]});
		cmd = '0;
		case (req.operation)
			OP_VALUE: begin
				if (!pending_q) begin
					cmd.err = 1'b1;
				end else begin
					cmd.nbytes = 3'd2;
					cmd.data[0] = req.register_value[15:8];
					cmd.data[1] = req.register_value[7:0];
					cmd.crc_append = (remaining_q == 7'd1);
				end
			end
			OP_WRITE_MULTI: begin
				if (bad_count) begin
					cmd.err = 1'b1;
				end else begin
					cmd.crc_init = 1'b1;
					cmd.nbytes = 3'd7;
					cmd.data[0] = req.slave_address;
					cmd.data[1] = FN_WRITE_MULTI;
					cmd.data[2] = req.register_address[15:8];
					cmd.data[3] = req.register_address[7:0];
					cmd.data[4] = req.quantity_or_value[15:8];
					cmd.data[5] = req.quantity_or_value[7:0];
					cmd.data[6] = {req.quantity_or_value[6:0], 1'b0};
				end
			end
			default: begin
				cmd.crc_init = 1'b1;
				cmd.crc_append = 1'b1;
				cmd.nbytes = 3'd6;
				cmd.data[0] = req.slave_address;
				cmd.data[1] = (req.operation == OP_READ_HOLDING) ? FN_READ_HOLDING
					: FN_WRITE_SINGLE;
				cmd.data[2] = req.register_address[15:8];
				cmd.data[3] = req.register_address[7:0];
				cmd.data[4] = req.quantity_or_value[15:8];
				cmd.data[5] = req.quantity_or_value[7:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			remaining_q <= '0;
		end else if (accept && !cmd.err) begin
			case (req.operation)
				OP_VALUE: begin
					remaining_q <= remaining_q - 7'd1;
					if (remaining_q == 7'd1) begin
						pending_q <= 1'b0;
					end
				end
				OP_WRITE_MULTI: begin
					pending_q <= 1'b1;
					remaining_q <= req.quantity_or_value[6:0];
				end
				default: begin
					pending_q <= 1'b0;
					remaining_q <= '0;
				end
			endcase
		end
	end

endmodule

// File: design/mrf_queue.sv
`timescale 1ns / 1ps

module mrf_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mrf_pkg::cmd_t push_data,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output mrf_pkg::cmd_t head
);
	import mrf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: design/mrf_back.sv
`timescale 1ns / 1ps

module mrf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  mrf_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          tx_valid,
	input  logic          tx_stall,
	output mrf_pkg::tx_t  tx
);
	import mrf_pkg::*;

	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        tx_valid_q;
	tx_t         tx_q;
	logic        advance;
	logic [3:0]  total;
	logic        last;
	logic        is_data;
	logic [7:0]  cur_byte;
	logic [15:0] crc_base;

	assign tx_valid = tx_valid_q;
	assign tx       = tx_q;
	assign advance  = cmd_valid && (!tx_valid_q || !tx_stall);
	assign cmd_pop  = advance && last;

	always_comb begin
		if (cmd.err) begin
			total = 4'd1;
		end else begin
			total = {1'b0, cmd.nbytes} + (cmd.crc_append ? 4'd2 : 4'd0);
		end
		last = ({1'b0, idx_q} == total - 4'd1);
		is_data = !cmd.err && (idx_q < cmd.nbytes);
		crc_base = (cmd.crc_init && idx_q == 3'd0) ? CRC_INIT : crc_q;
		if (cmd.err) begin
			cur_byte = 8'h00;
		end else if (is_data) begin
			cur_byte = cmd.data[idx_q];
		end else if (idx_q == cmd.nbytes) begin
			cur_byte = crc_q[7:0];
		end else begin
			cur_byte = crc_q[15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_q.tx_byte <= cur_byte;
			tx_q.last_byte <= last;
			tx_q.error <= cmd.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
			tx_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				tx_valid_q <= 1'b1;
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
				if (is_data) begin
					crc_q <= crc_add_byte(crc_base, cur_byte);
				end else if (!cmd.err && idx_q != cmd.nbytes) begin
					crc_q <= CRC_INIT;
				end
			end else if (!tx_stall) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/modbus_rtu_request_framer.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload   Handshake
// req      in         req_t     req_valid / req_stall
// tx       out        tx_t      tx_valid  / tx_stall
//
// Each request transaction produces one to eight byte transactions at one per cycle
// while tx_stall is low, so a read or write-single frame is eight byte transactions.
// The request side is stalled only while the command queue is full.
// Reset clears the queue, the pending write-multiple state and sets the CRC to all ones.
// A stalled byte transaction holds its payload and freezes the emitter and its CRC.

module modbus_rtu_request_framer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mrf_pkg::req_t req,
	output logic          tx_valid,
	input  logic          tx_stall,
	output mrf_pkg::tx_t  tx
);
	import mrf_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic accept;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	mrf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.cmd    (front_cmd)
	);

	mrf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head_cmd)
	);

	mrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.tx_valid  (tx_valid),
		.tx_stall  (tx_stall),
		.tx        (tx)
	);

endmodule

// File: tb/sv/modbus_rtu_request_framer_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_request_framer_tb;
	import mrf_pkg::*;

	localparam int DIRECTED_ITEMS = 24;
	localparam int RANDOM_ITEMS   = 356;
	localparam int HOLD_CYCLES    = 300;
	localparam int STALL_LIMIT    = 4000;

	class frame_predictor;
		logic [15:0] crc;
		logic [6:0]  values_left;
		bit          write_open;
		logic [7:0]  staged[$];
		tx_t         expected_bytes[$];
		int          mismatches;

		function new();
			crc = CRC_INIT;
			values_left = '0;
			write_open = 1'b0;
			mismatches = 0;
		endfunction

		function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
			return r;
		endfunction

		function void stage(input logic [7:0] b, input bit feed);
			if (feed) begin
				crc = crc_step(crc, b);
			end
			staged.push_back(b);
		endfunction

		function void stage_crc();
			logic [15:0] c;
			c = crc;
			stage(c[7:0], 1'b0);
			stage(c[15:8], 1'b0);
			crc = CRC_INIT;
		endfunction

		function void take_request(input req_t r);
			tx_t        t;
			logic [7:0] fn;
			if ((r.operation == OP_VALUE && !write_open) ||
			    (r.operation == OP_WRITE_MULTI && (r.quantity_or_value < 16'd1 ||
			     r.quantity_or_value > MAX_MULTI_COUNT))) begin
				t.tx_byte = 8'h00;
				t.last_byte = 1'b1;
				t.error = 1'b1;
				expected_bytes.push_back(t);
			end else begin
				if (r.operation == OP_VALUE) begin
					stage(r.register_value[15:8], 1'b1);
					stage(r.register_value[7:0], 1'b1);
					values_left = values_left - 7'd1;
					if (values_left == 7'd0) begin
						stage_crc();
						write_open = 1'b0;
					end
				end else begin
					// A new header drops any unfinished write-multiple frame.
					crc = CRC_INIT;
					write_open = 1'b0;
					values_left = '0;
					case (r.operation)
						OP_READ_HOLDING: fn = FN_READ_HOLDING;
						OP_WRITE_SINGLE: fn = FN_WRITE_SINGLE;
						default:         fn = FN_WRITE_MULTI;
					endcase
					stage(r.slave_address, 1'b1);
					stage(fn, 1'b1);
					stage(r.register_address[15:8], 1'b1);
					stage(r.register_address[7:0], 1'b1);
					stage(r.quantity_or_value[15:8], 1'b1);
					stage(r.quantity_or_value[7:0], 1'b1);
					if (r.operation == OP_WRITE_MULTI) begin
						stage({r.quantity_or_value[6:0], 1'b0}, 1'b1);
						values_left = r.quantity_or_value[6:0];
						write_open = 1'b1;
					end else begin
						stage_crc();
					end
				end
				foreach (staged[i]) begin
					t.tx_byte = staged[i];
					t.last_byte = (i == staged.size() - 1);
					t.error = 1'b0;
					expected_bytes.push_back(t);
				end
				staged.delete();
			end
		endfunction

		function void compare(input string field, input logic [7:0] want, input logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s expected %h actual %h", $time, field, want, got);
			end
		endfunction

		function void check_byte(input tx_t got);
			tx_t want;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: expected no transaction, actual tx_byte %h last_byte %b error %b",
					$time, got.tx_byte, got.last_byte, got.error);
			end else begin
				want = expected_bytes.pop_front();
				compare("tx_byte", want.tx_byte, got.tx_byte);
				compare("last_byte", {7'd0, want.last_byte}, {7'd0, got.last_byte});
				compare("error", {7'd0, want.error}, {7'd0, got.error});
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic tx_valid;
	logic tx_stall;
	tx_t  tx;

	bit             calm;
	bit             rx_hold_wanted;
	int             sent;
	int             idle_cycles;
	frame_predictor frames;

	always #5 clk = ~clk;

	modbus_rtu_request_framer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.tx_valid  (tx_valid),
		.tx_stall  (tx_stall),
		.tx        (tx)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				frames.take_request(req);
			end
			if (tx_valid && !tx_stall) begin
				frames.check_byte(tx);
			end
			if ((req_valid && !req_stall) || (tx_valid && !tx_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		tx_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_wanted) begin
				rx_hold_wanted = 1'b0;
				tx_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			tx_stall <= !calm && ($urandom_range(99) < 34);
		end
	end

	function automatic req_t build(input logic [1:0] op, input logic [7:0] slave,
		input logic [15:0] addr, input logic [15:0] qv, input logic [15:0] val);
		req_t r;
		r.operation = op;
		r.slave_address = slave;
		r.register_address = addr;
		r.quantity_or_value = qv;
		r.register_value = val;
		return r;
	endfunction

	task automatic send_req(input req_t r);
		while (!calm && $urandom_range(99) < 34) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_random(input logic [1:0] op, input logic [15:0] qv);
		send_req(build(op, 8'($urandom), 16'($urandom), qv, 16'($urandom)));
	endtask

	task automatic write_multi(input int count, input bit broken);
		int stop_at;
		stop_at = broken ? $urandom_range(count) : count;
		send_random(OP_WRITE_MULTI, 16'(count));
		for (int i = 0; i < stop_at; i++) begin
			send_random(OP_VALUE, 16'($urandom));
		end
		if (broken && stop_at == count) begin
			send_random(OP_VALUE, 16'($urandom));
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (frames.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int pick;
		frames = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		rx_hold_wanted = 1'b0;
		sent = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(build(OP_READ_HOLDING, 8'h00, 16'h0000, 16'h0000, 16'h0000));
		send_req(build(OP_READ_HOLDING, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_req(build(OP_WRITE_SINGLE, 8'h11, 16'h0001, 16'h0003, 16'hA5A5));
		send_req(build(OP_WRITE_SINGLE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000));
		send_req(build(OP_VALUE, 8'h01, 16'h0000, 16'h0000, 16'h1234));
		send_req(build(OP_WRITE_MULTI, 8'h01, 16'h0010, 16'd0, 16'h0000));
		send_req(build(OP_WRITE_MULTI, 8'h01, 16'h0010, 16'd124, 16'h0000));
		send_req(build(OP_WRITE_MULTI, 8'h01, 16'h0010, 16'hFFFF, 16'h0000));
		send_req(build(OP_WRITE_MULTI, 8'h00, 16'hFFFF, 16'd1, 16'h0000));
		send_req(build(OP_VALUE, 8'h00, 16'h0000, 16'h0000, 16'hFFFF));
		send_req(build(OP_VALUE, 8'h00, 16'h0000, 16'h0000, 16'h0000));
		send_req(build(OP_WRITE_MULTI, 8'hFF, 16'h0000, 16'd123, 16'h5555));
		send_req(build(OP_READ_HOLDING, 8'h22, 16'h1000, 16'd10, 16'hAAAA));
		send_req(build(OP_VALUE, 8'h22, 16'h1000, 16'd10, 16'hAAAA));
		send_req(build(OP_WRITE_MULTI, 8'h05, 16'h0100, 16'd2, 16'h0000));
		send_req(build(OP_VALUE, 8'h00, 16'h0000, 16'h0000, 16'h0102));
		send_req(build(OP_WRITE_MULTI, 8'h06, 16'h0200, 16'd2, 16'h0000));
		send_req(build(OP_VALUE, 8'h00, 16'h0000, 16'h0000, 16'h0304));
		send_req(build(OP_WRITE_MULTI, 8'h07, 16'h0300, 16'd0, 16'h0000));
		send_req(build(OP_VALUE, 8'h00, 16'h0000, 16'h0000, 16'h0506));
		send_req(build(OP_VALUE, 8'h00, 16'h0000, 16'h0000, 16'h0708));
		send_req(build(OP_WRITE_MULTI, 8'h08, 16'h0400, 16'd3, 16'h0000));
		send_req(build(OP_VALUE, 8'h00, 16'h0000, 16'h0000, 16'h090A));
		send_req(build(OP_WRITE_SINGLE, 8'h09, 16'h0500, 16'h0B0C, 16'h0000));
		wait_drained();

		// The receiver holds off while a full-length write-multiple frame is offered.
		rx_hold_wanted = 1'b1;
		write_multi(123, 1'b0);
		while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			calm = (sent >= 200 && sent < 280);
			pick = $urandom_range(99);
			if (pick < 20) begin
				send_random(OP_READ_HOLDING, 16'($urandom));
			end else if (pick < 38) begin
				send_random(OP_WRITE_SINGLE, 16'($urandom));
			end else if (pick < 85) begin
				write_multi(($urandom_range(19) == 0) ? $urandom_range(123, 7) :
					$urandom_range(6, 1), $urandom_range(9) == 0);
			end else if (pick < 93) begin
				send_random(OP_WRITE_MULTI,
					$urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 124)));
			end else begin
				send_random(OP_VALUE, 16'($urandom));
			end
		end
		calm = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (frames.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
